/* hw/rtl/bsc_pkg.sv */
`timescale 1ns / 1ps

package bsc_pkg;

  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 64;

  typedef struct packed {
    logic        action;
    logic [18:0] raw_value;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic               div_error;
  } out_item_t;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_CAL_ONE   = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_CAL_TWO   = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_CAL_THREE = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_OSS       = 2'd3;

  // item kinds
  localparam logic ACT_TEMP = 1'b0;
  localparam logic ACT_PRES = 1'b1;

  // compensation constants
  localparam logic [31:0] B6_OFS   = 32'd4000;
  localparam logic [31:0] B4_OFS   = 32'd32768;
  localparam logic [31:0] B7_SCALE = 32'd50000;
  localparam logic [31:0] P_K1     = 32'd3038;
  localparam logic [31:0] P_K2     = 32'hFFFF_E343;  // -7357
  localparam logic [31:0] P_K3     = 32'd3791;
  localparam logic [31:0] T_RND    = 32'd8;

endpackage

/* hw/rtl/baro_sensor_compensation_core.sv */
// The core takes a new item only in its idle state, after the previous item's result
// has been handed to the output register; a zero divisor skips the divide.
// Each item is sequenced through the shared 32x32 multiplier and, unless the
// divisor is zero, the one-bit-per-cycle 32-step divider.
// Reset: synchronous active-low rst_n clears calibration, oversampling,
// the kept temperature term and the control state.
`timescale 1ns / 1ps

module baro_sensor_compensation_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  bsc_pkg::in_item_t               in_item,
  output logic                            out_valid,
  input  logic                            out_ready,
  output bsc_pkg::out_item_t              out_item,
  input  logic                            cfg_we,
  input  logic [bsc_pkg::CfgIdxW-1:0]     cfg_index,
  input  logic [bsc_pkg::CfgDataW-1:0]    cfg_wdata
);
  import bsc_pkg::*;

  localparam logic [4:0] S_IDLE      = 5'd0;
  localparam logic [4:0] S_T_MUL     = 5'd1;
  localparam logic [4:0] S_T_DIVCHK  = 5'd2;
  localparam logic [4:0] S_DIV       = 5'd3;
  localparam logic [4:0] S_T_FIN     = 5'd4;
  localparam logic [4:0] S_P_SQ      = 5'd5;
  localparam logic [4:0] S_P_X1A     = 5'd6;
  localparam logic [4:0] S_P_X3A     = 5'd7;
  localparam logic [4:0] S_P_X1B     = 5'd8;
  localparam logic [4:0] S_P_X3B     = 5'd9;
  localparam logic [4:0] S_P_B4      = 5'd10;
  localparam logic [4:0] S_P_B7      = 5'd11;
  localparam logic [4:0] S_P_DIVFIN  = 5'd12;
  localparam logic [4:0] S_P_POST1   = 5'd13;
  localparam logic [4:0] S_P_POST2   = 5'd14;
  localparam logic [4:0] S_P_POST3   = 5'd15;
  localparam logic [4:0] S_OUT       = 5'd16;

  // control / config state
  logic [4:0]  state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [31:0] temp_term_r, temp_term_nxt;
  logic [63:0] cal1_r, cal2_r;
  logic [31:0] cal3_r;
  logic [1:0]  oss_r;

  // datapath registers
  logic        action_r, action_nxt;
  logic [18:0] raw_r, raw_nxt;
  logic [31:0] b6_r, b6_nxt;
  logic [31:0] sq_r, sq_nxt;
  logic [31:0] t_r, t_nxt;
  logic [31:0] b3_r, b3_nxt;
  logic [31:0] b4_r, b4_nxt;
  logic [31:0] p_r, p_nxt;
  logic [31:0] div_num_r, div_num_nxt;
  logic [31:0] div_den_r, div_den_nxt;
  logic [31:0] div_rem_r, div_rem_nxt;
  logic [4:0]  div_cnt_r, div_cnt_nxt;
  logic        div_flag_r, div_flag_nxt;  // temp: negate quotient, pressure: double it
  logic [31:0] res_value_r, res_value_nxt;
  logic        res_err_r, res_err_nxt;
  out_item_t   out_item_r, out_item_nxt;

  // calibration fields
  logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
  assign ac1 = {{16{cal1_r[63]}}, cal1_r[63:48]};
  assign ac2 = {{16{cal1_r[47]}}, cal1_r[47:32]};
  assign ac3 = {{16{cal1_r[31]}}, cal1_r[31:16]};
  assign ac4 = {16'd0, cal1_r[15:0]};
  assign ac5 = {16'd0, cal2_r[63:48]};
  assign ac6 = {16'd0, cal2_r[47:32]};
  assign b1  = {{16{cal2_r[31]}}, cal2_r[31:16]};
  assign b2  = {{16{cal2_r[15]}}, cal2_r[15:0]};
  assign mc  = {{16{cal3_r[31]}}, cal3_r[31:16]};
  assign md  = {{16{cal3_r[15]}}, cal3_r[15:0]};

  // shared multiplier, low 32 bits of the product
  logic [31:0] mul_a, mul_b, prod;
  logic [31:0] prod_s11, prod_s12, prod_s13, prod_s15, prod_s16;
  logic [31:0] p_s8;

  assign p_s8 = $signed(p_r) >>> 8;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_T_MUL: begin
        mul_a = {13'd0, raw_r} - ac6;
        mul_b = ac5;
      end
      S_P_SQ: begin
        mul_a = b6_r;
        mul_b = b6_r;
      end
      S_P_X1A: begin
        mul_a = b2;
        mul_b = sq_r;
      end
      S_P_X3A: begin
        mul_a = ac2;
        mul_b = b6_r;
      end
      S_P_X1B: begin
        mul_a = ac3;
        mul_b = b6_r;
      end
      S_P_X3B: begin
        mul_a = b1;
        mul_b = sq_r;
      end
      S_P_B4: begin
        mul_a = ac4;
        mul_b = t_r + B4_OFS;
      end
      S_P_B7: begin
        mul_a = {13'd0, raw_r} - b3_r;
        mul_b = B7_SCALE >> oss_r;
      end
      S_P_POST1: begin
        mul_a = p_s8;
        mul_b = p_s8;
      end
      S_P_POST2: begin
        mul_a = t_r;
        mul_b = P_K1;
      end
      S_P_POST3: begin
        mul_a = P_K2;
        mul_b = p_r;
      end
      default: ;
    endcase
  end

  assign prod     = mul_a * mul_b;
  assign prod_s11 = $signed(prod) >>> 11;
  assign prod_s12 = $signed(prod) >>> 12;
  assign prod_s13 = $signed(prod) >>> 13;
  assign prod_s15 = $signed(prod) >>> 15;
  assign prod_s16 = $signed(prod) >>> 16;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  always_comb begin
    logic [31:0] sum;
    logic [31:0] mc11;
    logic [31:0] quo;
    logic [31:0] sh;
    logic [32:0] rem_sh;
    logic [32:0] diff;

    sum    = '0;
    mc11   = '0;
    quo    = '0;
    sh     = '0;
    rem_sh = '0;
    diff   = '0;

    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_item_nxt  = out_item_r;
    temp_term_nxt = temp_term_r;
    action_nxt    = action_r;
    raw_nxt       = raw_r;
    b6_nxt        = b6_r;
    sq_nxt        = sq_r;
    t_nxt         = t_r;
    b3_nxt        = b3_r;
    b4_nxt        = b4_r;
    p_nxt         = p_r;
    div_num_nxt   = div_num_r;
    div_den_nxt   = div_den_r;
    div_rem_nxt   = div_rem_r;
    div_cnt_nxt   = div_cnt_r;
    div_flag_nxt  = div_flag_r;
    res_value_nxt = res_value_r;
    res_err_nxt   = res_err_r;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          action_nxt = in_item.action;
          raw_nxt    = in_item.raw_value;
          b6_nxt     = temp_term_r - B6_OFS;
          state_nxt  = (in_item.action == ACT_PRES) ? S_P_SQ : S_T_MUL;
        end
      end
      S_T_MUL: begin
        t_nxt     = prod_s15;
        state_nxt = S_T_DIVCHK;
      end
      S_T_DIVCHK: begin
        sum = t_r + md;
        if (sum == '0) begin
          res_value_nxt = '1;
          res_err_nxt   = 1'b1;
          state_nxt     = S_OUT;
        end else begin
          mc11         = mc << 11;
          div_num_nxt  = mc11[31] ? (32'd0 - mc11) : mc11;
          div_den_nxt  = sum[31] ? (32'd0 - sum) : sum;
          div_flag_nxt = mc11[31] ^ sum[31];
          div_rem_nxt  = '0;
          div_cnt_nxt  = '1;
          state_nxt    = S_DIV;
        end
      end
      S_DIV: begin
        // restoring divide, quotient bits shift into div_num_r
        rem_sh = {div_rem_r, div_num_r[31]};
        diff   = rem_sh - {1'b0, div_den_r};
        if (!diff[32]) begin
          div_rem_nxt = diff[31:0];
          div_num_nxt = {div_num_r[30:0], 1'b1};
        end else begin
          div_rem_nxt = rem_sh[31:0];
          div_num_nxt = {div_num_r[30:0], 1'b0};
        end
        div_cnt_nxt = div_cnt_r - 5'd1;
        if (div_cnt_r == '0) begin
          state_nxt = (action_r == ACT_PRES) ? S_P_DIVFIN : S_T_FIN;
        end
      end
      S_T_FIN: begin
        quo           = div_flag_r ? (32'd0 - div_num_r) : div_num_r;
        sum           = t_r + quo;
        temp_term_nxt = sum;
        res_value_nxt = $signed(sum + T_RND) >>> 4;
        res_err_nxt   = 1'b0;
        state_nxt     = S_OUT;
      end
      S_P_SQ: begin
        sq_nxt    = prod_s12;
        state_nxt = S_P_X1A;
      end
      S_P_X1A: begin
        t_nxt     = prod_s11;
        state_nxt = S_P_X3A;
      end
      S_P_X3A: begin
        t_nxt     = t_r + prod_s11;
        state_nxt = S_P_X1B;
      end
      S_P_X1B: begin
        // t_r holds x3 here; b3 needs no multiply
        sum       = ((ac1 << 2) + t_r) << oss_r;
        b3_nxt    = $signed(sum + 32'd2) >>> 2;
        t_nxt     = prod_s13;
        state_nxt = S_P_X3B;
      end
      S_P_X3B: begin
        sum       = t_r + prod_s16 + 32'd2;
        t_nxt     = $signed(sum) >>> 2;
        state_nxt = S_P_B4;
      end
      S_P_B4: begin
        b4_nxt    = prod >> 15;
        state_nxt = S_P_B7;
      end
      S_P_B7: begin
        if (b4_r == '0) begin
          res_value_nxt = '1;
          res_err_nxt   = 1'b1;
          state_nxt     = S_OUT;
        end else begin
          div_num_nxt  = prod[31] ? prod : (prod << 1);
          div_den_nxt  = b4_r;
          div_flag_nxt = prod[31];
          div_rem_nxt  = '0;
          div_cnt_nxt  = '1;
          state_nxt    = S_DIV;
        end
      end
      S_P_DIVFIN: begin
        p_nxt     = div_flag_r ? (div_num_r << 1) : div_num_r;
        state_nxt = S_P_POST1;
      end
      S_P_POST1: begin
        t_nxt     = prod;
        state_nxt = S_P_POST2;
      end
      S_P_POST2: begin
        t_nxt     = prod_s16;
        state_nxt = S_P_POST3;
      end
      S_P_POST3: begin
        sum           = t_r + prod_s16 + P_K3;
        sh            = $signed(sum) >>> 4;
        res_value_nxt = p_r + sh;
        res_err_nxt   = 1'b0;
        state_nxt     = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt          = 1'b1;
          out_item_nxt.value     = res_value_r;
          out_item_nxt.div_error = res_err_r;
          state_nxt              = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      temp_term_r <= '0;
      cal1_r      <= '0;
      cal2_r      <= '0;
      cal3_r      <= '0;
      oss_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      temp_term_r <= temp_term_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_CAL_ONE:   cal1_r <= cfg_wdata;
          CFG_CAL_TWO:   cal2_r <= cfg_wdata;
          CFG_CAL_THREE: cal3_r <= cfg_wdata[31:0];
          CFG_OSS:       oss_r  <= cfg_wdata[1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    out_item_r  <= out_item_nxt;
    action_r    <= action_nxt;
    raw_r       <= raw_nxt;
    b6_r        <= b6_nxt;
    sq_r        <= sq_nxt;
    t_r         <= t_nxt;
    b3_r        <= b3_nxt;
    b4_r        <= b4_nxt;
    p_r         <= p_nxt;
    div_num_r   <= div_num_nxt;
    div_den_r   <= div_den_nxt;
    div_rem_r   <= div_rem_nxt;
    div_cnt_r   <= div_cnt_nxt;
    div_flag_r  <= div_flag_nxt;
    res_value_r <= res_value_nxt;
    res_err_r   <= res_err_nxt;
  end

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r != S_IDLE))
    else $error("sequencer stayed idle after an item was accepted");

  a_div_exits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV && div_cnt_r == '0) |=> (state_r != S_DIV))
    else $error("divider ran past its last step");

  a_err_all_ones: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.div_error) |-> (out_item.value == '1))
    else $error("divide error result is not all ones");

  a_temp_term_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_T_FIN) |=> $stable(temp_term_r))
    else $error("kept temperature term changed outside temperature finish");
`endif

endmodule
